@@ hw/rtl/pgalloc_pkg.sv @@
package pgalloc_pkg;

  // Physical address width and free-count width are fixed by the interface.
  localparam int unsigned AddrWidth = 26;
  localparam int unsigned FreeWidth = 15;
  localparam int unsigned OutRefWidth = 8;
  localparam logic [FreeWidth-1:0] FreeMax = '1;

  // Operation codes; codes beyond peek behave as peek.
  typedef enum logic [2:0] {
    OpAlloc = 3'd0,
    OpFree  = 3'd1,
    OpInc   = 3'd2,
    OpDec   = 3'd3,
    OpPeek  = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StEmpty   = 2'd1,
    StBadAddr = 2'd2,
    StLimit   = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    SClear,
    SIdle,
    SExec
  } state_e;

  // Request word.
  typedef struct packed {
    logic [2:0]           op;
    logic [AddrWidth-1:0] addr;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [1:0]             status;
    logic [AddrWidth-1:0]   page_addr;
    logic [OutRefWidth-1:0] ref_count;
    logic [FreeWidth-1:0]   free_pages;
    logic                   page_released;
  } out_t;

endpackage

@@ hw/rtl/pgalloc_refs_mem.sv @@
// Reference-count memory: one read and one write port, registered read data,
// and a sweep after reset that zeroes every entry, one per cycle.
module pgalloc_refs_mem #(
  parameter int unsigned PAGE_COUNT = 16384,
  parameter int unsigned REF_WIDTH  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_addr_i,
  output logic [REF_WIDTH-1:0]          rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_addr_i,
  input  logic [REF_WIDTH-1:0]          wr_data_i,
  output logic                          busy_o
);

  localparam int unsigned PageW = $clog2(PAGE_COUNT);
  localparam logic [PageW-1:0] LastPage = PageW'(PAGE_COUNT - 1);

  logic [REF_WIDTH-1:0] refs_mem_q [PAGE_COUNT];
  logic [REF_WIDTH-1:0] rd_data_q;
  logic [PageW-1:0]     clr_q, clr_d;
  logic                 busy_q, busy_d;

  // The sweep walks every entry once after reset.
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + PageW'(1);
      if (clr_q == LastPage) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // Storage: the sweep has the write port until it is finished.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      refs_mem_q[clr_q] <= '0;
    end else if (wr_en_i) begin
      refs_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= refs_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

@@ hw/rtl/page_allocator_refcount_core.sv @@
// A request word is registered with the link and reference-count reads; its result word
// is written to the output register in the execute state. No request is taken during
// execution, set by the read-modify-write of the link and reference-count memories,
// each with a registered read. Reset: the list is empty, the free count and low bound
// are zero, and a sweep zeroes every reference count while no request is taken.
module page_allocator_refcount_core
  import pgalloc_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = 16384,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned REF_WIDTH  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [AddrWidth-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  localparam int unsigned PageW = $clog2(PAGE_COUNT);
  localparam logic [AddrWidth-1:0] PageCountA = AddrWidth'(PAGE_COUNT);
  localparam logic [REF_WIDTH-1:0] RefMax = '1;

  state_e state_q, state_d;

  logic [AddrWidth-1:0] low_bound_q;
  logic [PageW-1:0]     head_q, head_d;
  logic [FreeWidth-1:0] free_q, free_d;

  logic [PageW-1:0] link_mem_q [PAGE_COUNT];
  logic [PageW-1:0] link_rd_q;

  op_e              op_q;
  logic [PageW-1:0] pg_q;
  logic             bad_q;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic in_accept, exec_en, refs_busy;

  logic [AddrWidth-1:0] page_full;
  logic                 in_range, aligned, below, bad_in;
  logic [PageW-1:0]     pg_in;

  logic [REF_WIDTH-1:0] refs_rd, refs_wdata, ref_val, ref_dec;
  logic [PageW-1:0]     refs_waddr;
  logic                 refs_we;
  logic [PageW-1:0]     link_wdata;
  logic                 link_we;
  logic [REF_WIDTH+OutRefWidth-1:0] ref_ext;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bound_q <= '0;
    end else if (cfg_valid_i) begin
      low_bound_q <= cfg_data_i;
    end
  end

  // Next state of the controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SClear: begin
        if (!refs_busy) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_accept) begin
          state_d = SExec;
        end
      end
      SExec: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SClear;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o = 1'b0;
    exec_en    = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = !out_valid_q || out_ready_i;
      end
      SExec: begin
        exec_en = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  // Address checks on the incoming word.
  always_comb begin
    page_full = in_data_i.addr >> PAGE_SHIFT;
    in_range  = page_full < PageCountA;
    aligned   = in_data_i.addr[PAGE_SHIFT-1:0] == '0;
    below     = in_data_i.addr < low_bound_q;
    pg_in     = page_full[PageW-1:0];
    if (op_e'(in_data_i.op) == OpFree) begin
      bad_in = !aligned || below || !in_range;
    end else begin
      bad_in = !in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= op_e'(in_data_i.op);
      pg_q      <= pg_in;
      bad_q     <= bad_in;
      link_rd_q <= link_mem_q[head_q];
    end
  end

  pgalloc_refs_mem #(
    .PAGE_COUNT (PAGE_COUNT),
    .REF_WIDTH  (REF_WIDTH)
  ) u_refs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (pg_in),
    .rd_data_o (refs_rd),
    .wr_en_i   (refs_we),
    .wr_addr_i (refs_waddr),
    .wr_data_i (refs_wdata),
    .busy_o    (refs_busy)
  );

  // Operation: reads arrived last cycle, the write-back happens at this edge.
  always_comb begin
    head_d     = head_q;
    free_d     = free_q;
    refs_we    = 1'b0;
    refs_waddr = pg_q;
    refs_wdata = '0;
    link_we    = 1'b0;
    link_wdata = '0;
    ref_val    = '0;
    ref_dec    = (refs_rd != '0) ? refs_rd - REF_WIDTH'(1) : '0;
    out_d      = '0;
    out_d.status = StOk;
    unique case (op_q)
      OpAlloc: begin
        if (free_q == '0) begin
          out_d.status = StEmpty;
        end else begin
          free_d     = free_q - FreeWidth'(1);
          head_d     = link_rd_q;
          refs_we    = 1'b1;
          refs_waddr = head_q;
          refs_wdata = REF_WIDTH'(1);
          ref_val    = REF_WIDTH'(1);
          out_d.page_addr = AddrWidth'(head_q) << PAGE_SHIFT;
        end
      end
      OpFree: begin
        if (bad_q) begin
          out_d.status = StBadAddr;
        end else begin
          refs_we    = 1'b1;
          refs_wdata = ref_dec;
          ref_val    = ref_dec;
          if (ref_dec == '0) begin
            // Count reached zero, or was already zero: push the page.
            link_we    = 1'b1;
            link_wdata = (free_q == '0) ? '0 : head_q;
            head_d     = pg_q;
            free_d     = (free_q != FreeMax) ? free_q + FreeWidth'(1) : free_q;
            out_d.page_released = 1'b1;
          end
        end
      end
      OpInc: begin
        if (bad_q) begin
          out_d.status = StBadAddr;
        end else if (refs_rd == RefMax) begin
          out_d.status = StLimit;
          ref_val      = refs_rd;
        end else begin
          refs_we    = 1'b1;
          refs_wdata = refs_rd + REF_WIDTH'(1);
          ref_val    = refs_rd + REF_WIDTH'(1);
        end
      end
      OpDec: begin
        if (bad_q) begin
          out_d.status = StBadAddr;
        end else if (refs_rd == '0) begin
          out_d.status = StLimit;
        end else begin
          refs_we    = 1'b1;
          refs_wdata = ref_dec;
          ref_val    = ref_dec;
        end
      end
      default: begin
        // Peek, and the unused codes that behave as peek.
        if (bad_q) begin
          out_d.status = StBadAddr;
        end else begin
          ref_val = refs_rd;
        end
      end
    endcase
    if (!exec_en) begin
      head_d  = head_q;
      free_d  = free_q;
      refs_we = 1'b0;
      link_we = 1'b0;
    end
    ref_ext          = {{OutRefWidth{1'b0}}, ref_val};
    out_d.ref_count  = ref_ext[OutRefWidth-1:0];
    out_d.free_pages = free_d;
  end

  // Link memory write port.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem_q[pg_q] <= link_wdata;
    end
  end

  // Output register holds the result word until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      head_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // An accepted word is worked on in the following cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == SExec)
    else $error("accepted word not executed");

  // No word is taken while the count memory is being swept.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refs_busy |-> !in_ready_o)
    else $error("word accepted during sweep");

  // A new result appears only after an execute cycle.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == SExec)
    else $error("result without execution");

  // An empty report only comes with a zero free count.
  a_empty_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == StEmpty) |-> out_q.free_pages == '0)
    else $error("empty reported with free pages");
`endif

endmodule
